FILE: rtl/core/gec_pkg.sv
// Shared widths and the controller state type for the greedy edge colour assigner.
package gec_pkg;

    // Width of a vertex number on the input channel.
    localparam int VERTEX_W = 10;

    // Width of the colour index on the result channel.
    localparam int COLOR_OUT_W = 5;

    // Controller states, one-hot.
    typedef enum logic [3:0] {
        ST_CLR  = 4'b0001,
        ST_IDLE = 4'b0010,
        ST_CALC = 4'b0100,
        ST_WRB  = 4'b1000
    } state_t;

endpackage : gec_pkg

FILE: rtl/core/greedy_edge_color_assigner.sv
// Greedy edge colour assigner: per-vertex colour bitmaps in a memory, lowest-free-colour search.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------
//  s_      | in        | s_valid / s_ready  | s_vertex_a, s_vertex_b, s_last_edge
//  m_      | out       | m_valid / m_ready  | m_edge_color, m_no_color
//
// When beats follow one another, the accepting cycle issues both bitmap reads, the
// next cycle picks the colour and writes the first endpoint, and the cycle after that
// writes the second endpoint while the next edge is accepted.
// The bitmap memory's single write port puts the endpoint writes in different cycles.
// After reset, and after every edge marked last, a clearing pass writes zero to all
// VERTICES entries, one per cycle, during which no input beat is taken.
// A new beat is taken only when the result register is empty or being drained in the
// same cycle, so a stall on m_ready holds the input side after at most one result.
module greedy_edge_color_assigner #(
    parameter int VERTICES = 1024,
    parameter int COLORS   = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [gec_pkg::VERTEX_W-1:0]     s_vertex_a,
    input  logic [gec_pkg::VERTEX_W-1:0]     s_vertex_b,
    input  logic                             s_last_edge,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [gec_pkg::COLOR_OUT_W-1:0]  m_edge_color,
    output logic                             m_no_color
);
    import gec_pkg::*;

    // Address width of the bitmap memory and width of a colour index.
    localparam int AW  = $clog2(VERTICES);
    localparam int CIW = $clog2(COLORS);
    localparam int EW  = VERTEX_W + AW;
    localparam logic [EW-1:0] VERT_LIM = EW'(VERTICES);
    localparam logic [AW-1:0] CLR_END  = AW'(VERTICES - 1);

    // The bitmap store: one COLORS-bit word per vertex.
    logic [COLORS-1:0] mem [VERTICES];

    state_t state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;

    // Edge captured at acceptance.
    logic [AW-1:0] a_addr_reg, b_addr_reg;
    logic          a_in_reg, b_in_reg;
    logic          last_reg;

    // Registered read data of both endpoints.
    logic [COLORS-1:0] rd_a_reg, rd_b_reg;

    // Pending write of the second endpoint, also the forwarding source.
    logic              wb_en_reg, wb_en_next;
    logic [AW-1:0]     wb_addr_reg;
    logic [COLORS-1:0] wb_data_reg;
    logic              fwd_valid_reg, fwd_valid_next;

    // Result register.
    logic                    m_valid_reg, m_valid_next;
    logic [COLOR_OUT_W-1:0]  m_edge_color_reg;
    logic                    m_no_color_reg;

    logic accept;

    logic [EW-1:0] a_ext, b_ext;
    logic [AW-1:0] a_addr, b_addr;
    logic          a_in, b_in;

    logic [COLORS-1:0] eff_a, eff_b, used, color_bit, new_a, new_b;
    logic              found;
    logic [CIW-1:0]    color_idx;
    logic [CIW+COLOR_OUT_W-1:0] color_ext;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [COLORS-1:0] mem_wdata;

    // Vertex numbers are zero-extended then cut to the memory address; a number at or
    // above VERTICES reads as an empty bitmap and is never written.
    assign a_ext  = {{AW{1'b0}}, s_vertex_a};
    assign b_ext  = {{AW{1'b0}}, s_vertex_b};
    assign a_addr = a_ext[AW-1:0];
    assign b_addr = b_ext[AW-1:0];
    assign a_in   = (a_ext < VERT_LIM);
    assign b_in   = (b_ext < VERT_LIM);

    // Input is taken from idle, or while the previous edge writes its second endpoint,
    // provided the result register will be free by the time this edge produces a result.
    // After a last edge the clearing pass must run first.
    assign s_ready = ((state_reg == ST_IDLE) || ((state_reg == ST_WRB) && !last_reg))
                     && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    // An edge accepted while the previous edge writes its second endpoint reads the old
    // word of that entry, so the written word is forwarded in its place.
    always_comb begin
        eff_a = '0;
        eff_b = '0;
        if (a_in_reg) begin
            eff_a = (fwd_valid_reg && (a_addr_reg == wb_addr_reg)) ? wb_data_reg : rd_a_reg;
        end
        if (b_in_reg) begin
            eff_b = (fwd_valid_reg && (b_addr_reg == wb_addr_reg)) ? wb_data_reg : rd_b_reg;
        end
    end

    assign used = eff_a | eff_b;

    // Lowest colour free at both endpoints.
    always_comb begin
        found     = 1'b0;
        color_idx = '0;
        for (int i = COLORS - 1; i >= 0; i--) begin
            if (!used[i]) begin
                found     = 1'b1;
                color_idx = CIW'(i);
            end
        end
    end

    assign color_bit = {{(COLORS-1){1'b0}}, 1'b1} << color_idx;
    assign new_a     = eff_a | color_bit;
    assign new_b     = eff_b | color_bit;
    assign color_ext = {{COLOR_OUT_W{1'b0}}, color_idx};

    // The single write port is shared by the clearing pass and both endpoint updates.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = clr_cnt_reg;
        mem_wdata = '0;
        case (state_reg)
            ST_CLR: begin
                mem_we = 1'b1;
            end
            ST_CALC: begin
                mem_we    = found && a_in_reg;
                mem_waddr = a_addr_reg;
                mem_wdata = new_a;
            end
            ST_WRB: begin
                mem_we    = wb_en_reg;
                mem_waddr = wb_addr_reg;
                mem_wdata = wb_data_reg;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (accept) begin
            rd_a_reg <= mem[a_addr];
            rd_b_reg <= mem[b_addr];
        end
    end

    // Controller and result register next state.
    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        wb_en_next     = wb_en_reg;
        fwd_valid_next = accept && (state_reg == ST_WRB) && wb_en_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        case (state_reg)
            ST_CLR: begin
                if (clr_cnt_reg == CLR_END) begin
                    clr_cnt_next = '0;
                    state_next   = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                wb_en_next   = found && b_in_reg;
                m_valid_next = 1'b1;
                state_next   = ST_WRB;
            end
            ST_WRB: begin
                wb_en_next = 1'b0;
                if (last_reg) begin
                    clr_cnt_next = '0;
                    state_next   = ST_CLR;
                end else if (accept) begin
                    state_next = ST_CALC;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLR;
            clr_cnt_reg   <= '0;
            wb_en_reg     <= 1'b0;
            fwd_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            wb_en_reg     <= wb_en_next;
            fwd_valid_reg <= fwd_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            a_addr_reg <= a_addr;
            b_addr_reg <= b_addr;
            a_in_reg   <= a_in;
            b_in_reg   <= b_in;
            last_reg   <= s_last_edge;
        end
        if (state_reg == ST_CALC) begin
            wb_addr_reg      <= b_addr_reg;
            wb_data_reg      <= new_b;
            m_edge_color_reg <= found ? color_ext[COLOR_OUT_W-1:0] : '0;
            m_no_color_reg   <= !found;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_edge_color = m_edge_color_reg;
    assign m_no_color   = m_no_color_reg;

`ifndef SYNTH
    // The result register is always free when an edge reaches its colour choice.
    a_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CALC) |-> !m_valid_reg)
        else $error("result register occupied at colour choice");

    // Every colour choice leaves a result beat behind it.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CALC) |=> m_valid_reg)
        else $error("colour choice produced no result");

    // Forwarding only ever feeds the colour choice.
    a_fwd_in_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_valid_reg |-> (state_reg == ST_CALC))
        else $error("forwarding flag outside colour choice");

    // An exhausted edge leaves the store unchanged.
    a_no_write_exhausted: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_CALC) && !found) |=> !mem_we)
        else $error("store written for an edge without a colour");
`endif

endmodule : greedy_edge_color_assigner

FILE: dv/gec_tb_pkg.sv
// Scoreboard for the greedy edge colour assigner: bitmap predictor and queue of awaited results.
package gec_tb_pkg;

    import gec_pkg::*;

    class edge_color_book #(int VERTICES = 1024, int COLORS = 32);

        typedef struct {
            logic [COLOR_OUT_W-1:0] color;
            logic                   none;
        } outcome_t;

        logic [COLORS-1:0] used_map [VERTICES];
        outcome_t          awaited [$];
        int                fails;

        function new();
            fails = 0;
            wipe();
        endfunction

        function void wipe();
            foreach (used_map[v]) begin
                used_map[v] = '0;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Colours one accepted edge and queues the result it must produce.
        function void note_edge(input logic [VERTEX_W-1:0] a, input logic [VERTEX_W-1:0] b,
                                input logic is_last);
            logic [COLORS-1:0] taken;
            outcome_t          o;
            int                pick;
            taken = '0;
            pick  = -1;
            if (a < VERTICES) taken |= used_map[a];
            if (b < VERTICES) taken |= used_map[b];
            for (int c = COLORS - 1; c >= 0; c--) begin
                if (!taken[c]) pick = c;
            end
            o.none  = (pick < 0);
            o.color = o.none ? '0 : COLOR_OUT_W'(pick);
            if (!o.none) begin
                if (a < VERTICES) used_map[a][pick] = 1'b1;
                if (b < VERTICES) used_map[b][pick] = 1'b1;
            end
            if (is_last) wipe();
            awaited.push_back(o);
        endfunction

        function void check_result(input logic [COLOR_OUT_W-1:0] color, input logic none);
            outcome_t want;
            if (awaited.size() == 0) begin
                $error("result beat with nothing outstanding: edge_color %0d no_color %0b",
                       color, none);
                fails++;
                return;
            end
            want = awaited.pop_front();
            if (color !== want.color) begin
                $error("edge_color: expected %0d, got %0d", want.color, color);
                fails++;
            end
            if (none !== want.none) begin
                $error("no_color: expected %0b, got %0b", want.none, none);
                fails++;
            end
        endfunction

    endclass

endpackage : gec_tb_pkg

FILE: dv/tb.sv
// Self-checking testbench for the greedy edge colour assigner.
module tb;

    import gec_pkg::*;
    import gec_tb_pkg::*;

    localparam int NUM_VERTICES = 1024;
    localparam int NUM_COLORS   = 32;

    // Longest run of cycles without any beat on either channel. The slowest legal stretch
    // is a clearing pass plus the longest gap on each side, so this leaves a margin of
    // several times that.
    localparam int IDLE_LIMIT   = 5000;

    // Number of edges after which the random stimulus stops.
    localparam int EDGE_TARGET  = 1400;

    // Cycles allowed to pass once nothing is outstanding, so that a stray result shows up.
    localparam int TAIL_CYCLES  = 16;

    // Shapes of random graph. Stars and hammered pairs pile colours onto one vertex until
    // the palette runs out; dense graphs mix many shared endpoints; noise is unstructured.
    typedef enum {
        G_STAR,
        G_HAMMER,
        G_DENSE,
        G_NOISE
    } graph_shape_t;

    // Scoreboard specialised for the configuration under test.
    typedef edge_color_book #(.VERTICES(NUM_VERTICES), .COLORS(NUM_COLORS)) book_t;

    logic                   aclk         = 1'b0;
    logic                   aresetn      = 1'b0;
    logic                   s_valid      = 1'b0;
    logic                   s_ready;
    logic [VERTEX_W-1:0]    s_vertex_a   = '0;
    logic [VERTEX_W-1:0]    s_vertex_b   = '0;
    logic                   s_last_edge  = 1'b0;
    logic                   m_valid;
    logic                   m_ready      = 1'b0;
    logic [COLOR_OUT_W-1:0] m_edge_color;
    logic                   m_no_color;

    // While set, neither side inserts gaps, so beats follow one another at full rate.
    bit steady     = 1'b0;
    int edges_sent = 0;
    int idle_count = 0;

    book_t book = new();

    greedy_edge_color_assigner #(
        .VERTICES (NUM_VERTICES),
        .COLORS   (NUM_COLORS)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_vertex_a   (s_vertex_a),
        .s_vertex_b   (s_vertex_b),
        .s_last_edge  (s_last_edge),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_edge_color (m_edge_color),
        .m_no_color   (m_no_color)
    );

    always #5 aclk = ~aclk;

    // Gap length for either side: mostly none, sometimes a few cycles, now and then a long
    // pause, so that holes land on every phase of the edge pipeline.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Presents one edge beat and returns at the clock edge where it is taken. Valid stays
    // high afterwards, so a back-to-back beat needs no second assignment in the same step.
    task automatic send_edge(input logic [VERTEX_W-1:0] a, input logic [VERTEX_W-1:0] b,
                             input logic is_last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_vertex_a  <= a;
        s_vertex_b  <= b;
        s_last_edge <= is_last;
        do @(posedge aclk); while (!s_ready);
        book.note_edge(a, b, is_last);
        edges_sent++;
    endtask

    // One random graph. Most graphs close with a last edge, which empties the store; the
    // rest run on into the next graph so that colours carry over. With strict set, a hammer
    // graph repeats a single pair well past exhaustion and closes on an uncoloured edge.
    task automatic run_graph(input graph_shape_t shape, input bit strict);
        logic [VERTEX_W-1:0] pool [16];
        logic [VERTEX_W-1:0] a, b, leaf;
        int                  pool_n, n;
        bit                  closes, is_last;
        pool_n = $urandom_range(2, 16);
        foreach (pool[i]) begin
            pool[i] = VERTEX_W'($urandom);
        end
        closes = strict || ($urandom_range(0, 9) != 0);
        steady = !strict && ($urandom_range(0, 4) == 0);
        // A hammered self loop fills a single vertex on its own.
        if (shape == G_HAMMER && !strict && $urandom_range(0, 5) == 0) pool[1] = pool[0];
        case (shape)
            G_STAR:   n = $urandom_range(20, 40);
            G_HAMMER: n = $urandom_range(34, 40);
            G_DENSE:  n = $urandom_range(8, 60);
            default:  n = $urandom_range(1, 30);
        endcase
        for (int k = 0; k < n; k++) begin
            case (shape)
                G_STAR: begin
                    leaf = VERTEX_W'($urandom);
                    if ($urandom_range(0, 1)) begin
                        a = pool[0];
                        b = leaf;
                    end else begin
                        a = leaf;
                        b = pool[0];
                    end
                end
                G_HAMMER: begin
                    a = pool[0];
                    b = pool[1];
                    if (!strict && $urandom_range(0, 7) == 0) b = pool[$urandom_range(0, pool_n - 1)];
                    if ($urandom_range(0, 1)) {a, b} = {b, a};
                end
                G_DENSE: begin
                    a = pool[$urandom_range(0, pool_n - 1)];
                    b = pool[$urandom_range(0, pool_n - 1)];
                end
                default: begin
                    a = VERTEX_W'($urandom);
                    b = VERTEX_W'($urandom);
                end
            endcase
            // Noise may also drop a last edge in the middle of its run.
            if (k == n - 1) is_last = closes;
            else is_last = (shape == G_NOISE) && ($urandom_range(0, 39) == 0);
            send_edge(a, b, is_last);
        end
    endtask

    initial begin : stimulus
        graph_shape_t shape;
        int           r;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed edges: extreme vertex numbers, alternating bit patterns, self loops,
        // the same edge back to back so that the second read must see the first write,
        // and a last edge, then an edge on one of its ends to show the store was emptied.
        send_edge(10'd0,     10'd1023,  1'b0);
        send_edge(10'd1023,  10'd0,     1'b0);
        send_edge(10'd0,     10'd0,     1'b0);
        send_edge(10'd1023,  10'd1023,  1'b0);
        send_edge(10'h155,   10'h2AA,   1'b0);
        send_edge(10'h2AA,   10'h155,   1'b0);
        send_edge(10'h155,   10'h2AA,   1'b0);
        send_edge(10'd0,     10'h155,   1'b0);
        send_edge(10'h2AA,   10'd1023,  1'b1);
        send_edge(10'd0,     10'd1023,  1'b0);
        send_edge(10'd0,     10'd1023,  1'b1);

        // Run a pair out of colours first, so that exhaustion and a last edge that gets
        // no colour are always covered whatever the seed.
        run_graph(G_HAMMER, 1'b1);

        while (edges_sent < EDGE_TARGET) begin
            r = $urandom_range(0, 9);
            shape = (r < 2) ? G_STAR : (r < 4) ? G_HAMMER : (r < 8) ? G_DENSE : G_NOISE;
            run_graph(shape, 1'b0);
        end
        s_valid <= 1'b0;
        steady = 1'b0;

        while (book.pending() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (book.fails == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Result side: checks each beat taken at this edge, then decides the ready level for
    // the next cycle. Stalls use the same gap profile as the input side.
    initial begin : result_sink
        int hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) book.check_result(m_edge_color, m_no_color);
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else begin
                hold = pick_gap();
                m_ready <= (hold == 0);
            end
        end
    end

    // Watchdog: a hang shows up as a long stretch with no beat on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_count <= 0;
        end else if (idle_count >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

endmodule : tb
